// ===== rtl/dms_pkg.sv =====
package dms_pkg;

  localparam int unsigned SLOT_COUNT = 32;
  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  localparam logic [1:0] REQ_POST   = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  typedef struct packed {
    logic [15:0] name;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [31:0] stamp;
    logic [31:0] delay;
    logic [31:0] payload;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

endpackage

// ===== rtl/dms_ram.sv =====
module dms_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/delayed_message_scheduler_unit.sv =====
// Channel  Direction  tdata (low bit up)                                 tuser
// s_axis   in         msg_tag, src_id, dst_id, delay_ticks, extra_data   req_type
// m_axis   out        out_name, out_sender, out_receiver, out_payload    from_queue
//
// A post, cancel or tick passes through the SCAN, DRAIN and COMMIT states before
// the next item can be taken; the single read port of the slot memory visits one
// entry per cycle. A post with zero delay goes straight to COMMIT and an unused
// request type straight back to idle. Reset clears all slot valid bits and the time
// at once, with no clearing pass. A result waits in the output register, and
// the block holds before delivery only while that register is full and stalled.
module delayed_message_scheduler_unit
  import dms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // msg_tag, src_id, dst_id, delay_ticks, extra_data
  input  logic [95:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_name, out_sender, out_receiver, out_payload
  output logic [63:0] m_axis_tdata,
  // from_queue
  output logic        m_axis_tuser
);

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        cnt_q, cnt_d;
  logic                    chk_vld_q;
  logic [IDX_W-1:0]        chk_idx_q;
  logic [1:0]              req_q, req_d;
  entry_t                  in_q, in_d;
  logic [SLOT_COUNT-1:0]   valid_q, valid_d;
  logic [31:0]             time_q, time_d;
  logic                    dup_q, dup_d;
  logic                    free_found_q, free_found_d;
  logic [IDX_W-1:0]        free_idx_q, free_idx_d;
  logic                    best_found_q, best_found_d;
  logic [31:0]             best_due_q, best_due_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  entry_t                  best_q, best_d;
  logic                    out_vld_q, out_vld_d;
  logic [63:0]             out_data_q, out_data_d;
  logic                    out_user_q, out_user_d;

  logic                    s_acc;
  logic                    out_free;
  logic                    ram_we;
  logic [ENTRY_W-1:0]      ram_rdata;
  entry_t                  rd_e;
  logic                    hit_v;
  logic [31:0]             age;
  logic [31:0]             due;
  logic                    has_res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign rd_e          = entry_t'(ram_rdata);
  assign hit_v         = chk_vld_q && valid_q[chk_idx_q];
  assign age           = time_q - rd_e.stamp;
  assign due           = rd_e.stamp + rd_e.delay;
  assign has_res       = ((req_q == REQ_POST) && (in_q.delay == 32'd0)) ||
                         ((req_q == REQ_TICK) && best_found_q);
  assign ram_we        = (state_q == ST_COMMIT) && (req_q == REQ_POST) &&
                         (in_q.delay != 32'd0) && !dup_q && free_found_q;

  dms_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i(in_q),
    .re_i   (state_q == ST_SCAN),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    req_d        = req_q;
    in_d         = in_q;
    valid_d      = valid_q;
    time_d       = time_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_found_d = best_found_q;
    best_due_d   = best_due_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;

    if (chk_vld_q) begin
      unique case (req_q)
        REQ_POST: begin
          if (hit_v && (rd_e.name == in_q.name) && (rd_e.sender == in_q.sender) &&
              (rd_e.receiver == in_q.receiver)) begin
            dup_d = 1'b1;
          end
          if (!valid_q[chk_idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = chk_idx_q;
          end
        end
        REQ_CANCEL: begin
          if (hit_v && ((in_q.name == 16'd0) || (rd_e.name == in_q.name)) &&
              ((in_q.receiver == 8'd0) || (rd_e.receiver == in_q.receiver))) begin
            valid_d[chk_idx_q] = 1'b0;
          end
        end
        REQ_TICK: begin
          if (hit_v && (age >= rd_e.delay) && (!best_found_q || (due < best_due_q))) begin
            best_found_d = 1'b1;
            best_due_d   = due;
            best_idx_d   = chk_idx_q;
            best_d       = rd_e;
          end
        end
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          req_d        = s_axis_tuser;
          in_d.name    = s_axis_tdata[15:0];
          in_d.sender  = s_axis_tdata[23:16];
          in_d.receiver = s_axis_tdata[31:24];
          in_d.delay   = s_axis_tdata[63:32];
          in_d.payload = s_axis_tdata[95:64];
          in_d.stamp   = time_q;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          best_found_d = 1'b0;
          cnt_d        = '0;
          priority if (s_axis_tuser == REQ_POST && s_axis_tdata[63:32] == 32'd0) begin
            state_d = ST_COMMIT;
          end else if (s_axis_tuser == REQ_POST || s_axis_tuser == REQ_CANCEL) begin
            state_d = ST_SCAN;
          end else if (s_axis_tuser == REQ_TICK) begin
            time_d  = time_q + 32'd1;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_SLOT) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!has_res || out_free) begin
          state_d = ST_IDLE;
          if (ram_we) begin
            valid_d[free_idx_q] = 1'b1;
          end
          if (req_q == REQ_TICK && best_found_q) begin
            valid_d[best_idx_q] = 1'b0;
            out_vld_d  = 1'b1;
            out_data_d = {best_q.payload, best_q.receiver, best_q.sender, best_q.name};
            out_user_d = 1'b1;
          end else if (has_res) begin
            out_vld_d  = 1'b1;
            out_data_d = {in_q.payload, in_q.receiver, in_q.sender, in_q.name};
            out_user_d = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chk_vld_q <= 1'b0;
      valid_q   <= '0;
      time_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= (state_q == ST_SCAN);
      valid_q   <= valid_d;
      time_q    <= time_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    chk_idx_q    <= cnt_q;
    req_q        <= req_d;
    in_q         <= in_d;
    dup_q        <= dup_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    best_found_q <= best_found_d;
    best_due_q   <= best_due_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register is not one-hot");

  a_write_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !valid_q[free_idx_q])
    else $error("post overwrites an occupied slot");

  a_best_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT && req_q == REQ_TICK && best_found_q) |-> valid_q[best_idx_q])
    else $error("tick selected an empty slot");

  a_tick_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT && req_q == REQ_TICK && best_found_q && out_free)
    |=> !valid_q[$past(best_idx_q)] && m_axis_tvalid && m_axis_tuser)
    else $error("delivered slot not freed or result missing");

  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser == REQ_TICK) |=> time_q == $past(time_q) + 32'd1)
    else $error("tick did not advance time");
`endif

endmodule

// ===== tb/delivery_checker.sv =====
module delivery_checker
  import dms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [95:0] req_data_i,
  input  logic [1:0]  req_kind_i,
  input  logic        dlv_valid_i,
  input  logic        dlv_ready_i,
  input  logic [63:0] dlv_data_i,
  input  logic        dlv_from_queue_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] name;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [31:0] payload;
    logic        from_queue;
  } delivery_t;

  logic        slot_used [SLOT_COUNT];
  entry_t      slot_msg  [SLOT_COUNT];
  logic [31:0] tick_count;
  delivery_t   expected_deliveries [$];

  // Applies one accepted request to the mirrored table and queues the
  // delivery it causes, if any.
  function automatic void predict_delivery(input logic [1:0] kind, input logic [95:0] data);
    entry_t      msg;
    delivery_t   dlv;
    int          free_slot;
    int          best_slot;
    bit          duplicate;
    bit          found;
    logic [31:0] elapsed;
    logic [31:0] due_at;
    logic [31:0] best_due;
    msg.name     = data[15:0];
    msg.sender   = data[23:16];
    msg.receiver = data[31:24];
    msg.delay    = data[63:32];
    msg.payload  = data[95:64];
    msg.stamp    = tick_count;
    free_slot    = -1;
    best_slot    = 0;
    duplicate    = 1'b0;
    found        = 1'b0;
    best_due     = '0;
    case (kind)
      REQ_POST: begin
        if (msg.delay == 32'd0) begin
          dlv.name       = msg.name;
          dlv.sender     = msg.sender;
          dlv.receiver   = msg.receiver;
          dlv.payload    = msg.payload;
          dlv.from_queue = 1'b0;
          expected_deliveries.push_back(dlv);
        end else begin
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (slot_used[k]) begin
              if (slot_msg[k].name == msg.name && slot_msg[k].sender == msg.sender &&
                  slot_msg[k].receiver == msg.receiver) begin
                duplicate = 1'b1;
              end
            end else if (free_slot < 0) begin
              free_slot = k;
            end
          end
          if (!duplicate && free_slot >= 0) begin
            slot_msg[free_slot]  = msg;
            slot_used[free_slot] = 1'b1;
          end
        end
      end
      REQ_CANCEL: begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
          if (slot_used[k] && (msg.name == 16'd0 || slot_msg[k].name == msg.name) &&
              (msg.receiver == 8'd0 || slot_msg[k].receiver == msg.receiver)) begin
            slot_used[k] = 1'b0;
          end
        end
      end
      REQ_TICK: begin
        tick_count = tick_count + 32'd1;
        for (int k = 0; k < SLOT_COUNT; k++) begin
          elapsed = tick_count - slot_msg[k].stamp;
          due_at  = slot_msg[k].stamp + slot_msg[k].delay;
          if (slot_used[k] && elapsed >= slot_msg[k].delay && (!found || due_at < best_due)) begin
            found     = 1'b1;
            best_due  = due_at;
            best_slot = k;
          end
        end
        if (found) begin
          slot_used[best_slot] = 1'b0;
          dlv.name       = slot_msg[best_slot].name;
          dlv.sender     = slot_msg[best_slot].sender;
          dlv.receiver   = slot_msg[best_slot].receiver;
          dlv.payload    = slot_msg[best_slot].payload;
          dlv.from_queue = 1'b1;
          expected_deliveries.push_back(dlv);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    delivery_t got;
    delivery_t want;
    if (!rst_ni) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        slot_used[k] = 1'b0;
      end
      tick_count = '0;
      expected_deliveries.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (dlv_valid_i && dlv_ready_i) begin
        got.name       = dlv_data_i[15:0];
        got.sender     = dlv_data_i[23:16];
        got.receiver   = dlv_data_i[31:24];
        got.payload    = dlv_data_i[63:32];
        got.from_queue = dlv_from_queue_i;
        if (expected_deliveries.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%0t: unexpected item: name %h sender %h receiver %h payload %h queued %b",
                     $realtime, got.name, got.sender, got.receiver, got.payload,
                     got.from_queue);
          end
        end else begin
          want = expected_deliveries.pop_front();
          if (got.name !== want.name || got.sender !== want.sender ||
              got.receiver !== want.receiver || got.payload !== want.payload ||
              got.from_queue !== want.from_queue) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: item differs: expected name %h sender %h receiver %h payload %h %s",
                       $realtime, want.name, want.sender, want.receiver, want.payload,
                       want.from_queue ? "queued" : "immediate");
              $display("%0t:                  got name %h sender %h receiver %h payload %h %s",
                       $realtime, got.name, got.sender, got.receiver, got.payload,
                       got.from_queue ? "queued" : "immediate");
            end
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        predict_delivery(req_kind_i, req_data_i);
      end
      pending_o = expected_deliveries.size();
    end
  end

endmodule

// ===== tb/tb_delayed_message_scheduler_unit.sv =====
module tb_delayed_message_scheduler_unit;
  import dms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned REQUEST_TARGET = 1800;
  localparam int unsigned HOLD_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned requests_sent = 0;
  bit          hold_req = 1'b0;
  bit          hold_active = 1'b0;
  bit          drain_all = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  delayed_message_scheduler_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  delivery_checker i_delivery_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_i      (s_axis_tready),
    .req_data_i       (s_axis_tdata),
    .req_kind_i       (s_axis_tuser),
    .dlv_valid_i      (m_axis_tvalid),
    .dlv_ready_i      (m_axis_tready),
    .dlv_data_i       (m_axis_tdata),
    .dlv_from_queue_i (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  task automatic send_request(input logic [1:0] kind, input logic [15:0] name,
                              input logic [7:0] sender, input logic [7:0] receiver,
                              input logic [31:0] delay, input logic [31:0] payload);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {payload, delay, receiver, sender, name};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind != REQ_UNUSED) begin
      requests_sent++;
    end
  endtask

  task automatic sender_pause(input bit steady);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(99);
    if (steady || r < 65) begin
      gap = 0;
    end else if (r < 95) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 40);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Half of the keys come from a tiny pool so that duplicates and cancel hits are common.
  function automatic logic [15:0] pick_key(input int unsigned span);
    if ($urandom_range(1) == 0) begin
      return 16'($urandom_range(0, 3));
    end
    return 16'($urandom_range(0, span));
  endfunction

  function automatic logic [31:0] pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      return 32'd0;
    end else if (r < 80) begin
      return 32'($urandom_range(1, 24));
    end else if (r < 95) begin
      return 32'($urandom_range(25, 300));
    end
    return $urandom();
  endfunction

  task automatic send_random(input int unsigned post_pct, input int unsigned tick_pct,
                             input bit steady);
    int unsigned r;
    logic [15:0] name;
    logic [15:0] receiver;
    r = $urandom_range(99);
    if (r < post_pct) begin
      send_request(REQ_POST, pick_key(65535), 8'(pick_key(255)), 8'(pick_key(255)),
                   pick_delay(), $urandom());
    end else if (r < post_pct + tick_pct) begin
      send_request(REQ_TICK, 16'($urandom()), 8'($urandom()), 8'($urandom()), $urandom(),
                   $urandom());
    end else if (r < 98) begin
      name     = ($urandom_range(9) < 3) ? 16'd0 : pick_key(65535);
      receiver = ($urandom_range(9) < 3) ? 16'd0 : pick_key(255);
      send_request(REQ_CANCEL, name, 8'($urandom()), 8'(receiver), $urandom(), $urandom());
    end else begin
      send_request(REQ_UNUSED, 16'($urandom()), 8'($urandom()), 8'($urandom()), $urandom(),
                   $urandom());
    end
    sender_pause(steady);
  endtask

  initial begin
    int unsigned r;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(99);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
      end else if (drain_all) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if (r < 50) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else if (r < 92) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_len;
    int unsigned post_pct;
    int unsigned tick_pct;
    int unsigned mix;
    bit          steady;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_request(REQ_POST, 16'h0000, 8'h00, 8'h00, 32'd0, 32'h0000_0000);
    sender_pause(1'b0);
    send_request(REQ_POST, 16'hFFFF, 8'hFF, 8'hFF, 32'd0, 32'hFFFF_FFFF);
    sender_pause(1'b0);
    send_request(REQ_POST, 16'h0000, 8'h01, 8'h01, 32'd1, 32'hA5A5_5A5A);
    sender_pause(1'b0);
    send_request(REQ_POST, 16'h0000, 8'h01, 8'h01, 32'd1, 32'h1234_5678);
    sender_pause(1'b0);
    send_request(REQ_POST, 16'h0005, 8'h02, 8'h07, 32'd3, 32'h0000_0005);
    sender_pause(1'b0);
    send_request(REQ_TICK, 16'h0000, 8'h00, 8'h00, 32'd0, 32'd0);
    sender_pause(1'b0);
    send_request(REQ_TICK, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sender_pause(1'b0);
    send_request(REQ_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 32'd0, 32'hFFFF_FFFF);
    sender_pause(1'b0);
    send_request(REQ_TICK, 16'h0000, 8'h00, 8'h00, 32'd0, 32'd0);
    sender_pause(1'b0);
    send_request(REQ_POST, 16'h0014, 8'h03, 8'h04, 32'd5, 32'h0000_0014);
    sender_pause(1'b0);
    send_request(REQ_POST, 16'h0015, 8'h03, 8'h04, 32'd2, 32'h0000_0015);
    sender_pause(1'b0);
    send_request(REQ_POST, 16'h0016, 8'h03, 8'h04, 32'd2, 32'h0000_0016);
    sender_pause(1'b0);
    repeat (6) begin
      send_request(REQ_TICK, 16'h0000, 8'h00, 8'h00, 32'd0, 32'd0);
      sender_pause(1'b0);
    end
    send_request(REQ_POST, 16'h001E, 8'h01, 8'h08, 32'd50, 32'h0000_001E);
    sender_pause(1'b0);
    send_request(REQ_POST, 16'h001F, 8'h01, 8'h08, 32'd50, 32'h0000_001F);
    sender_pause(1'b0);
    send_request(REQ_POST, 16'h001E, 8'h01, 8'h09, 32'hFFFF_FFFF, 32'h0000_0020);
    sender_pause(1'b0);
    send_request(REQ_CANCEL, 16'h001E, 8'h00, 8'h00, 32'd0, 32'd0);
    sender_pause(1'b0);
    send_request(REQ_CANCEL, 16'h0000, 8'h00, 8'h08, 32'd0, 32'd0);
    sender_pause(1'b0);
    send_request(REQ_CANCEL, 16'h0000, 8'h00, 8'h00, 32'd0, 32'd0);
    sender_pause(1'b0);

    phase = 0;
    while (requests_sent < REQUEST_TARGET) begin
      if (phase == 1 || phase == 6) begin
        hold_req = 1'b1;
        wait (hold_active);
        repeat (12) begin
          send_request(REQ_POST, 16'($urandom()), 8'($urandom()), 8'($urandom()), 32'd0,
                       $urandom());
        end
      end
      mix       = $urandom_range(2);
      post_pct  = (mix == 0) ? 70 : (mix == 1) ? 40 : 20;
      tick_pct  = (mix == 0) ? 15 : (mix == 1) ? 45 : 70;
      steady    = ($urandom_range(3) == 0);
      phase_len = $urandom_range(60, 150);
      repeat (phase_len) begin
        send_random(post_pct, tick_pct, steady);
      end
      phase++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    drain_all = 1'b1;
    repeat (SLOT_COUNT + 10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[delayed_message_scheduler_unit] OK");
    end else begin
      $display("[delayed_message_scheduler_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[delayed_message_scheduler_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dms_pkg.sv
rtl/dms_ram.sv
rtl/delayed_message_scheduler_unit.sv
tb/delivery_checker.sv
tb/tb_delayed_message_scheduler_unit.sv
